### rtl/fvhp_pkg.sv
`default_nettype none

package fvhp_pkg;

   localparam int POS_WIDTH = 9;
   localparam logic [POS_WIDTH-1:0] LAST_POS = 9'd511;
   localparam logic [POS_WIDTH-1:0] SIG_FIRST_POS = 9'd510;
   localparam logic [POS_WIDTH-1:0] MBR_TABLE_BASE = 9'd446;
   localparam logic [POS_WIDTH-1:0] MBR_ENTRY_BYTES = 9'd16;

   localparam logic [7:0] BYTE_SIG_FIRST = 8'h55;
   localparam logic [7:0] BYTE_SIG_SECOND = 8'hAA;
   localparam logic [7:0] PART_TYPE_FAT32_LBA = 8'h0C;
   localparam logic [7:0] FAT_COPIES_EXPECTED = 8'd2;
   localparam logic [15:0] SECTOR_SIZE_EXPECTED = 16'd512;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = 1;
   localparam int QUEUE_COUNT_WIDTH = 2;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_NUMBER = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARTITION_INDEX = 1'd1;

   typedef enum logic [3:0] {
      FLD_NONE,
      FLD_PART_TYPE,
      FLD_PART_START,
      FLD_PART_LENGTH,
      FLD_SIG_FIRST,
      FLD_SIG_SECOND,
      FLD_BYTES_PER_SECTOR,
      FLD_CLUSTER_SIZE,
      FLD_RESERVED,
      FLD_FAT_COPIES,
      FLD_ROOT_ENTRIES,
      FLD_OLD_FAT_SIZE,
      FLD_FAT_SIZE,
      FLD_ROOT_CLUSTER
   } field_type;

   typedef enum logic [3:0] {
      STATUS_OK          = 4'd0,
      STATUS_DEVICE      = 4'd1,
      STATUS_PARTITION   = 4'd2,
      STATUS_MBR_READ    = 4'd3,
      STATUS_MBR_SIG     = 4'd4,
      STATUS_TYPE        = 4'd5,
      STATUS_BOOT_READ   = 4'd6,
      STATUS_BOOT_SIG    = 4'd7,
      STATUS_SECTOR_SIZE = 4'd8,
      STATUS_FAT_COUNT   = 4'd9,
      STATUS_INVALID     = 4'd10
   } status_type;

   typedef enum logic {
      KIND_READ_REQUEST = 1'b0,
      KIND_MOUNT_RESULT = 1'b1
   } kind_type;

   // One classified byte as it travels from the front to the back.
   typedef struct packed {
      logic [7:0] byte_value;
      logic       read_failed;
      logic       sector_end;
      field_type  mbr_field;
      logic [1:0] mbr_lane;
      field_type  boot_field;
      logic [1:0] boot_lane;
   } entry_type;

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [31:0] lba;
      logic [31:0] size_in_sectors;
      logic [31:0] sectors_per_fat;
      logic [7:0]  sectors_per_cluster;
      logic [31:0] root_cluster;
      logic [31:0] fat_start_sector;
      logic [31:0] data_start_sector;
   } rsp_type;

   function automatic logic [31:0] put_byte32(input logic [31:0] word, input logic [1:0] lane,
                                              input logic [7:0] value);
      logic [31:0] result;
      result = word;
      case (lane)
         2'd0: result[7:0] = value;
         2'd1: result[15:8] = value;
         2'd2: result[23:16] = value;
         default: result[31:24] = value;
      endcase
      return result;
   endfunction

   function automatic logic [15:0] put_byte16(input logic [15:0] word, input logic lane,
                                              input logic [7:0] value);
      logic [15:0] result;
      result = word;
      if (lane) begin
         result[15:8] = value;
      end else begin
         result[7:0] = value;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

### rtl/fvhp_front.sv
`default_nettype none

module fvhp_front import fvhp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [7:0] req_byte_value,
   input  wire logic       req_read_failed,
   input  wire logic [2:0] partition_index,
   input  wire logic       push_ready,
   output logic            push_valid,
   output entry_type       push_entry
);

   logic [POS_WIDTH-1:0] byte_position_ff;
   logic [POS_WIDTH-1:0] byte_position_in;
   logic [POS_WIDTH-1:0] table_base;
   logic [POS_WIDTH-1:0] entry_offset;
   logic                 in_entry;
   logic                 sector_end;
   logic                 accept;

   assign accept = req_valid && push_ready;
   assign sector_end = req_read_failed || (byte_position_ff == LAST_POS);
   assign push_valid = req_valid;

   // The position counter restarts at every sector end, including a failed read.
   always_comb begin
      byte_position_in = byte_position_ff;
      if (accept) begin
         byte_position_in = sector_end ? '0 : byte_position_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
      end else begin
         byte_position_ff <= byte_position_in;
      end
   end

   assign table_base = MBR_TABLE_BASE + {3'b000, partition_index[1:0], 4'b0000};
   assign entry_offset = byte_position_ff - table_base;
   assign in_entry = !partition_index[2] && (byte_position_ff >= table_base)
                     && (entry_offset < MBR_ENTRY_BYTES);

   always_comb begin
      push_entry.byte_value = req_byte_value;
      push_entry.read_failed = req_read_failed;
      push_entry.sector_end = sector_end;
      push_entry.mbr_lane = entry_offset[1:0];
      push_entry.mbr_field = FLD_NONE;
      push_entry.boot_field = FLD_NONE;
      push_entry.boot_lane = byte_position_ff[1:0];

      if (byte_position_ff == SIG_FIRST_POS) begin
         push_entry.mbr_field = FLD_SIG_FIRST;
      end else if (byte_position_ff == LAST_POS) begin
         push_entry.mbr_field = FLD_SIG_SECOND;
      end else if (in_entry) begin
         if (entry_offset == 9'd4) begin
            push_entry.mbr_field = FLD_PART_TYPE;
         end else if (entry_offset[3:2] == 2'd2) begin
            push_entry.mbr_field = FLD_PART_START;
         end else if (entry_offset[3:2] == 2'd3) begin
            push_entry.mbr_field = FLD_PART_LENGTH;
         end
      end

      unique case (byte_position_ff) inside
         9'd11, 9'd12: begin
            push_entry.boot_field = FLD_BYTES_PER_SECTOR;
            push_entry.boot_lane = {1'b0, byte_position_ff == 9'd12};
         end
         9'd13: push_entry.boot_field = FLD_CLUSTER_SIZE;
         9'd14, 9'd15: begin
            push_entry.boot_field = FLD_RESERVED;
            push_entry.boot_lane = {1'b0, byte_position_ff == 9'd15};
         end
         9'd16: push_entry.boot_field = FLD_FAT_COPIES;
         9'd17, 9'd18: begin
            push_entry.boot_field = FLD_ROOT_ENTRIES;
            push_entry.boot_lane = {1'b0, byte_position_ff == 9'd18};
         end
         9'd22, 9'd23: begin
            push_entry.boot_field = FLD_OLD_FAT_SIZE;
            push_entry.boot_lane = {1'b0, byte_position_ff == 9'd23};
         end
         [9'd36:9'd39]: push_entry.boot_field = FLD_FAT_SIZE;
         [9'd44:9'd47]: push_entry.boot_field = FLD_ROOT_CLUSTER;
         9'd510: push_entry.boot_field = FLD_SIG_FIRST;
         9'd511: push_entry.boot_field = FLD_SIG_SECOND;
         default: push_entry.boot_field = FLD_NONE;
      endcase
   end

endmodule

`default_nettype wire

### rtl/fvhp_queue.sv
`default_nettype none

module fvhp_queue import fvhp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_valid,
   input  wire entry_type  push_entry,
   output logic            push_ready,
   input  wire logic       pop,
   output logic            head_valid,
   output entry_type       head_entry
);

   entry_type                    entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff;
   logic [QUEUE_COUNT_WIDTH-1:0] count_in;
   logic                         do_push;
   logic                         do_pop;

   assign push_ready = (count_ff != QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### rtl/fvhp_back.sv
`default_nettype none

module fvhp_back import fvhp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [2:0] device_number,
   input  wire logic [2:0] partition_index,
   input  wire logic       head_valid,
   input  wire entry_type  head_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data
);

   logic        in_boot_ff, in_boot_in;
   logic        part_type_ok_ff, part_type_ok_in;
   logic        first_sig_ok_ff, first_sig_ok_in;
   logic [31:0] part_start_ff, part_start_in;
   logic [31:0] part_length_ff, part_length_in;
   logic [15:0] bytes_per_sector_ff, bytes_per_sector_in;
   logic [7:0]  cluster_size_ff, cluster_size_in;
   logic [15:0] reserved_ff, reserved_in;
   logic [7:0]  fat_copies_ff, fat_copies_in;
   logic [15:0] root_entries_ff, root_entries_in;
   logic [15:0] old_fat_size_ff, old_fat_size_in;
   logic [31:0] fat_size_ff, fat_size_in;
   logic [31:0] root_cluster_ff, root_cluster_in;
   logic [31:0] fat_start_ff;
   logic [31:0] data_start;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   field_type   field;
   logic [1:0]  lane;
   logic [7:0]  value;
   logic        sig_ok;
   logic        emit;

   assign field = in_boot_ff ? head_entry.boot_field : head_entry.mbr_field;
   assign lane = in_boot_ff ? head_entry.boot_lane : head_entry.mbr_lane;
   assign value = head_entry.byte_value;

   // Only a sector end produces a result, so only that transaction waits for the
   // output register; all other bytes drain at one per cycle.
   assign pop = head_valid && (!head_entry.sector_end || !rsp_valid_ff || rsp_ready);
   assign emit = pop && head_entry.sector_end;
   assign sig_ok = !head_entry.read_failed && first_sig_ok_ff && (value == BYTE_SIG_SECOND);

   // The FAT start only changes well before the last byte of a sector, so it is
   // precomputed here and the sector end adds just the FAT area.
   assign data_start = fat_start_ff + {fat_size_ff[30:0], 1'b0};

   always_comb begin
      in_boot_in = in_boot_ff;
      part_type_ok_in = part_type_ok_ff;
      first_sig_ok_in = first_sig_ok_ff;
      part_start_in = part_start_ff;
      part_length_in = part_length_ff;
      bytes_per_sector_in = bytes_per_sector_ff;
      cluster_size_in = cluster_size_ff;
      reserved_in = reserved_ff;
      fat_copies_in = fat_copies_ff;
      root_entries_in = root_entries_ff;
      old_fat_size_in = old_fat_size_ff;
      fat_size_in = fat_size_ff;
      root_cluster_in = root_cluster_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;

      if (pop && !head_entry.read_failed) begin
         case (field)
            FLD_PART_TYPE: part_type_ok_in = (value == PART_TYPE_FAT32_LBA);
            FLD_PART_START: part_start_in = put_byte32(part_start_ff, lane, value);
            FLD_PART_LENGTH: part_length_in = put_byte32(part_length_ff, lane, value);
            FLD_SIG_FIRST: first_sig_ok_in = (value == BYTE_SIG_FIRST);
            FLD_BYTES_PER_SECTOR:
               bytes_per_sector_in = put_byte16(bytes_per_sector_ff, lane[0], value);
            FLD_CLUSTER_SIZE: cluster_size_in = value;
            FLD_RESERVED: reserved_in = put_byte16(reserved_ff, lane[0], value);
            FLD_FAT_COPIES: fat_copies_in = value;
            FLD_ROOT_ENTRIES: root_entries_in = put_byte16(root_entries_ff, lane[0], value);
            FLD_OLD_FAT_SIZE: old_fat_size_in = put_byte16(old_fat_size_ff, lane[0], value);
            FLD_FAT_SIZE: fat_size_in = put_byte32(fat_size_ff, lane, value);
            FLD_ROOT_CLUSTER: root_cluster_in = put_byte32(root_cluster_ff, lane, value);
            default: ;
         endcase
      end

      if (emit) begin
         first_sig_ok_in = 1'b0;
         part_type_ok_in = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in = '0;
         rsp_data_in.kind = KIND_MOUNT_RESULT;
         if (!in_boot_ff) begin
            if (device_number != '0) begin
               rsp_data_in.status = STATUS_DEVICE;
            end else if (partition_index[2]) begin
               rsp_data_in.status = STATUS_PARTITION;
            end else if (head_entry.read_failed) begin
               rsp_data_in.status = STATUS_MBR_READ;
            end else if (!sig_ok) begin
               rsp_data_in.status = STATUS_MBR_SIG;
            end else if (!part_type_ok_ff) begin
               rsp_data_in.status = STATUS_TYPE;
            end else begin
               rsp_data_in.kind = KIND_READ_REQUEST;
               rsp_data_in.status = STATUS_OK;
               rsp_data_in.lba = part_start_ff;
               rsp_data_in.size_in_sectors = part_length_ff;
               in_boot_in = 1'b1;
            end
         end else begin
            in_boot_in = 1'b0;
            if (head_entry.read_failed) begin
               rsp_data_in.status = STATUS_BOOT_READ;
            end else if (!sig_ok) begin
               rsp_data_in.status = STATUS_BOOT_SIG;
            end else if (bytes_per_sector_ff != SECTOR_SIZE_EXPECTED) begin
               rsp_data_in.status = STATUS_SECTOR_SIZE;
            end else if (fat_copies_ff != FAT_COPIES_EXPECTED) begin
               rsp_data_in.status = STATUS_FAT_COUNT;
            end else if (root_entries_ff != '0 || old_fat_size_ff != '0) begin
               rsp_data_in.status = STATUS_INVALID;
            end else begin
               rsp_data_in.status = STATUS_OK;
               rsp_data_in.lba = part_start_ff;
               rsp_data_in.size_in_sectors = part_length_ff;
               rsp_data_in.sectors_per_fat = fat_size_ff;
               rsp_data_in.sectors_per_cluster = cluster_size_ff;
               rsp_data_in.root_cluster = root_cluster_ff;
               rsp_data_in.fat_start_sector = fat_start_ff;
               rsp_data_in.data_start_sector = data_start;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_boot_ff <= 1'b0;
         part_type_ok_ff <= 1'b0;
         first_sig_ok_ff <= 1'b0;
         part_start_ff <= '0;
         part_length_ff <= '0;
         bytes_per_sector_ff <= '0;
         cluster_size_ff <= '0;
         reserved_ff <= '0;
         fat_copies_ff <= '0;
         root_entries_ff <= '0;
         old_fat_size_ff <= '0;
         fat_size_ff <= '0;
         root_cluster_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_boot_ff <= in_boot_in;
         part_type_ok_ff <= part_type_ok_in;
         first_sig_ok_ff <= first_sig_ok_in;
         part_start_ff <= part_start_in;
         part_length_ff <= part_length_in;
         bytes_per_sector_ff <= bytes_per_sector_in;
         cluster_size_ff <= cluster_size_in;
         reserved_ff <= reserved_in;
         fat_copies_ff <= fat_copies_in;
         root_entries_ff <= root_entries_in;
         old_fat_size_ff <= old_fat_size_in;
         fat_size_ff <= fat_size_in;
         root_cluster_ff <= root_cluster_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fat_start_ff <= part_start_ff + {16'h0000, reserved_ff};
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/fat32_volume_header_parser.sv
`default_nettype none

// Parses the MBR sector and then the FAT32 boot sector of the selected partition,
// one byte per transaction, and sustains one byte per clock cycle. A position
// tracker classifies each byte and passes it through a two-entry queue to the
// capture unit, which updates the partition and volume fields and, at the end of
// each sector, loads one result into the output register. Only the transaction
// that ends a sector waits for that register to be free, so a stalled result
// holds back the stream once the queue is full. After an accepted MBR the block
// emits a boot sector read request and expects the boot sector next; after the
// boot sector, or after any error, it emits the mount result and expects an MBR
// again. A sector's last byte passes the queue and then the output register.
module fat32_volume_header_parser import fvhp_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wen,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [7:0]                 req_byte_value,
   input  wire logic                       req_read_failed,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_kind,
   output logic [3:0]                      rsp_status,
   output logic [31:0]                     rsp_lba,
   output logic [31:0]                     rsp_size_in_sectors,
   output logic [31:0]                     rsp_sectors_per_fat,
   output logic [7:0]                      rsp_sectors_per_cluster,
   output logic [31:0]                     rsp_root_cluster,
   output logic [31:0]                     rsp_fat_start_sector,
   output logic [31:0]                     rsp_data_start_sector
);

   logic [2:0] device_number_ff;
   logic [2:0] partition_index_ff;
   logic       push_valid;
   logic       push_ready;
   entry_type  push_entry;
   logic       head_valid;
   entry_type  head_entry;
   logic       pop;
   rsp_type    rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_number_ff <= '0;
         partition_index_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_DEVICE_NUMBER: device_number_ff <= csr_wdata;
            CSR_PARTITION_INDEX: partition_index_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = push_ready;

   fvhp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_byte_value  (req_byte_value),
      .req_read_failed (req_read_failed),
      .partition_index (partition_index_ff),
      .push_ready      (push_ready),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   fvhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   fvhp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .device_number   (device_number_ff),
      .partition_index (partition_index_ff),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

   assign rsp_kind = rsp_data.kind;
   assign rsp_status = rsp_data.status;
   assign rsp_lba = rsp_data.lba;
   assign rsp_size_in_sectors = rsp_data.size_in_sectors;
   assign rsp_sectors_per_fat = rsp_data.sectors_per_fat;
   assign rsp_sectors_per_cluster = rsp_data.sectors_per_cluster;
   assign rsp_root_cluster = rsp_data.root_cluster;
   assign rsp_fat_start_sector = rsp_data.fat_start_sector;
   assign rsp_data_start_sector = rsp_data.data_start_sector;

endmodule

`default_nettype wire

### tb/tb_fat32_volume_header_parser.sv
module tb_fat32_volume_header_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import fvhp_pkg::*;

   localparam int HOLD_CYCLES = 200;
   localparam int RANDOM_PHASES = 10;
   localparam int ATTEMPTS_PER_PHASE = 4;
   localparam int SHORT_SECTOR_LAST = 15;

   // Byte offsets inside a partition entry and inside the boot sector.
   localparam int ENTRY_TYPE = 4;
   localparam int ENTRY_START = 8;
   localparam int ENTRY_LENGTH = 12;
   localparam int OFS_BPS = 11;
   localparam int OFS_SPC = 13;
   localparam int OFS_RESERVED = 14;
   localparam int OFS_FAT_COPIES = 16;
   localparam int OFS_ROOT_ENTRIES = 17;
   localparam int OFS_OLD_FAT_SIZE = 22;
   localparam int OFS_FAT_SIZE = 36;
   localparam int OFS_ROOT_CLUSTER = 44;

   typedef struct packed {
      logic [7:0] value;
      logic       failed;
   } sector_byte_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wen = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_byte_value = 8'h00;
   logic                       req_read_failed = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_kind;
   logic [3:0]                 rsp_status;
   logic [31:0]                rsp_lba;
   logic [31:0]                rsp_size_in_sectors;
   logic [31:0]                rsp_sectors_per_fat;
   logic [7:0]                 rsp_sectors_per_cluster;
   logic [31:0]                rsp_root_cluster;
   logic [31:0]                rsp_fat_start_sector;
   logic [31:0]                rsp_data_start_sector;

   fat32_volume_header_parser u_top (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wen                (csr_wen),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_byte_value         (req_byte_value),
      .req_read_failed        (req_read_failed),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_kind               (rsp_kind),
      .rsp_status             (rsp_status),
      .rsp_lba                (rsp_lba),
      .rsp_size_in_sectors    (rsp_size_in_sectors),
      .rsp_sectors_per_fat    (rsp_sectors_per_fat),
      .rsp_sectors_per_cluster(rsp_sectors_per_cluster),
      .rsp_root_cluster       (rsp_root_cluster),
      .rsp_fat_start_sector   (rsp_fat_start_sector),
      .rsp_data_start_sector  (rsp_data_start_sector)
   );

   always #5 clock = ~clock;

   // Mirror of the configuration registers and of the parser state.
   logic [2:0]  cfg_device = '0;
   logic [2:0]  cfg_partition = '0;
   logic [8:0]  sector_pos = '0;
   logic        in_boot = 1'b0;
   logic [31:0] part_start_seen = '0;
   logic [31:0] part_length_seen = '0;
   logic        part_type_seen = 1'b0;
   logic        first_sig_seen = 1'b0;
   logic [15:0] bps_seen = '0;
   logic [7:0]  copies_seen = '0;
   logic [15:0] root_entries_seen = '0;
   logic [15:0] old_fat_seen = '0;
   logic [15:0] reserved_seen = '0;
   logic [7:0]  spc_seen = '0;
   logic [31:0] fat_size_seen = '0;
   logic [31:0] root_cluster_seen = '0;

   rsp_type         expected_mounts[$];
   sector_byte_type byte_stream[$];
   logic [7:0]      sector_img[0:511];
   int              bytes_sent = 0;
   int              bytes_accepted = 0;
   int              mismatch_count = 0;
   int              send_idle = 0;
   int              recv_idle = 0;
   int              hold_left = 0;
   int              holds_requested = 0;
   int              holds_started = 0;
   sector_byte_type next_byte;
   rsp_type         want_mount;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // Advances the parser mirror by one byte and queues the result a sector end produces.
   task automatic predict_mount_step(input logic [7:0] b, input logic failed);
      int          pos;
      int          base;
      logic        sig_ok;
      logic        type_ok;
      logic [31:0] fat_start;
      rsp_type     r;
      pos = int'(sector_pos);
      sig_ok = 1'b0;
      r = '0;
      if (!failed) begin
         if (pos == int'(LAST_POS)) begin
            sig_ok = first_sig_seen && b == BYTE_SIG_SECOND;
         end else if (in_boot) begin
            if (pos == OFS_BPS || pos == OFS_BPS + 1) begin
               bps_seen[(pos - OFS_BPS) * 8 +: 8] = b;
            end else if (pos == OFS_SPC) begin
               spc_seen = b;
            end else if (pos == OFS_RESERVED || pos == OFS_RESERVED + 1) begin
               reserved_seen[(pos - OFS_RESERVED) * 8 +: 8] = b;
            end else if (pos == OFS_FAT_COPIES) begin
               copies_seen = b;
            end else if (pos == OFS_ROOT_ENTRIES || pos == OFS_ROOT_ENTRIES + 1) begin
               root_entries_seen[(pos - OFS_ROOT_ENTRIES) * 8 +: 8] = b;
            end else if (pos == OFS_OLD_FAT_SIZE || pos == OFS_OLD_FAT_SIZE + 1) begin
               old_fat_seen[(pos - OFS_OLD_FAT_SIZE) * 8 +: 8] = b;
            end else if (pos >= OFS_FAT_SIZE && pos < OFS_FAT_SIZE + 4) begin
               fat_size_seen[(pos - OFS_FAT_SIZE) * 8 +: 8] = b;
            end else if (pos >= OFS_ROOT_CLUSTER && pos < OFS_ROOT_CLUSTER + 4) begin
               root_cluster_seen[(pos - OFS_ROOT_CLUSTER) * 8 +: 8] = b;
            end else if (pos == int'(SIG_FIRST_POS)) begin
               first_sig_seen = (b == BYTE_SIG_FIRST);
            end
         end else begin
            if (cfg_partition < 3'd4) begin
               base = int'(MBR_TABLE_BASE) + int'(MBR_ENTRY_BYTES) * int'(cfg_partition);
               if (pos == base + ENTRY_TYPE) begin
                  part_type_seen = (b == PART_TYPE_FAT32_LBA);
               end else if (pos >= base + ENTRY_START && pos < base + ENTRY_LENGTH) begin
                  part_start_seen[(pos - base - ENTRY_START) * 8 +: 8] = b;
               end else if (pos >= base + ENTRY_LENGTH && pos < base + 16) begin
                  part_length_seen[(pos - base - ENTRY_LENGTH) * 8 +: 8] = b;
               end
            end
            if (pos == int'(SIG_FIRST_POS)) first_sig_seen = (b == BYTE_SIG_FIRST);
         end
      end
      if (!failed && pos != int'(LAST_POS)) begin
         sector_pos = sector_pos + 9'd1;
         return;
      end
      sector_pos = '0;
      first_sig_seen = 1'b0;
      r.kind = KIND_MOUNT_RESULT;
      if (!in_boot) begin
         type_ok = part_type_seen;
         part_type_seen = 1'b0;
         // Register checks come ahead of the read error and the sector contents.
         if (cfg_device != 3'd0) r.status = STATUS_DEVICE;
         else if (cfg_partition >= 3'd4) r.status = STATUS_PARTITION;
         else if (failed) r.status = STATUS_MBR_READ;
         else if (!sig_ok) r.status = STATUS_MBR_SIG;
         else if (!type_ok) r.status = STATUS_TYPE;
         else begin
            r.kind = KIND_READ_REQUEST;
            r.status = STATUS_OK;
            r.lba = part_start_seen;
            r.size_in_sectors = part_length_seen;
            in_boot = 1'b1;
         end
      end else begin
         in_boot = 1'b0;
         part_type_seen = 1'b0;
         if (failed) r.status = STATUS_BOOT_READ;
         else if (!sig_ok) r.status = STATUS_BOOT_SIG;
         else if (bps_seen != SECTOR_SIZE_EXPECTED) r.status = STATUS_SECTOR_SIZE;
         else if (copies_seen != FAT_COPIES_EXPECTED) r.status = STATUS_FAT_COUNT;
         else if (root_entries_seen != 16'd0 || old_fat_seen != 16'd0) begin
            r.status = STATUS_INVALID;
         end else begin
            fat_start = part_start_seen + {16'h0, reserved_seen};
            r.status = STATUS_OK;
            r.lba = part_start_seen;
            r.size_in_sectors = part_length_seen;
            r.sectors_per_fat = fat_size_seen;
            r.sectors_per_cluster = spc_seen;
            r.root_cluster = root_cluster_seen;
            r.fat_start_sector = fat_start;
            r.data_start_sector = fat_start + (fat_size_seen << 1);
         end
      end
      expected_mounts.push_back(r);
   endtask

   // Sender: one transaction per byte, random gaps after each acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_idle = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_mount_step(req_byte_value, req_read_failed);
            bytes_accepted++;
         end
         if (req_valid && !req_ready) begin
            // Hold the offered byte until the block takes it.
         end else if (send_idle > 0) begin
            send_idle--;
            req_valid <= 1'b0;
         end else if (byte_stream.size() > 0) begin
            next_byte = byte_stream.pop_front();
            req_valid <= 1'b1;
            req_byte_value <= next_byte.value;
            req_read_failed <= next_byte.failed;
            send_idle = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_idle = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_started != holds_requested) begin
         holds_started++;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (recv_idle > 0) begin
         recv_idle--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         recv_idle = pick_gap();
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_mounts.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got kind %0d status %0d",
                     $time, rsp_kind, rsp_status);
            mismatch_count++;
         end else begin
            want_mount = expected_mounts.pop_front();
            check_field("kind", 32'(want_mount.kind), 32'(rsp_kind));
            check_field("status", 32'(want_mount.status), 32'(rsp_status));
            check_field("lba", want_mount.lba, rsp_lba);
            check_field("size_in_sectors", want_mount.size_in_sectors, rsp_size_in_sectors);
            check_field("sectors_per_fat", want_mount.sectors_per_fat, rsp_sectors_per_fat);
            check_field("sectors_per_cluster", 32'(want_mount.sectors_per_cluster),
                        32'(rsp_sectors_per_cluster));
            check_field("root_cluster", want_mount.root_cluster, rsp_root_cluster);
            check_field("fat_start_sector", want_mount.fat_start_sector,
                        rsp_fat_start_sector);
            check_field("data_start_sector", want_mount.data_start_sector,
                        rsp_data_start_sector);
         end
      end
   end

   // Sector image construction.
   task automatic fill_noise();
      for (int i = 0; i < 512; i++) sector_img[i] = 8'($urandom);
   endtask

   task automatic put_le(input int offset, input int count, input logic [31:0] v);
      for (int i = 0; i < count; i++) sector_img[offset + i] = v[8 * i +: 8];
   endtask

   task automatic put_sig();
      sector_img[int'(SIG_FIRST_POS)] = BYTE_SIG_FIRST;
      sector_img[int'(LAST_POS)] = BYTE_SIG_SECOND;
   endtask

   task automatic build_mbr(input int slot, input logic [31:0] start,
                            input logic [31:0] length);
      int base;
      fill_noise();
      base = int'(MBR_TABLE_BASE) + int'(MBR_ENTRY_BYTES) * slot;
      sector_img[base + ENTRY_TYPE] = PART_TYPE_FAT32_LBA;
      put_le(base + ENTRY_START, 4, start);
      put_le(base + ENTRY_LENGTH, 4, length);
      put_sig();
   endtask

   task automatic build_boot(input logic [7:0] spc, input logic [15:0] reserved,
                             input logic [31:0] fat_size, input logic [31:0] root_cluster);
      fill_noise();
      put_le(OFS_BPS, 2, 32'(SECTOR_SIZE_EXPECTED));
      sector_img[OFS_SPC] = spc;
      put_le(OFS_RESERVED, 2, 32'(reserved));
      sector_img[OFS_FAT_COPIES] = FAT_COPIES_EXPECTED;
      put_le(OFS_ROOT_ENTRIES, 2, 32'h0);
      put_le(OFS_OLD_FAT_SIZE, 2, 32'h0);
      put_le(OFS_FAT_SIZE, 4, fat_size);
      put_le(OFS_ROOT_CLUSTER, 4, root_cluster);
      put_sig();
   endtask

   task automatic push_span(input int first, input int last, input logic fail_last);
      sector_byte_type item;
      for (int i = first; i <= last; i++) begin
         item.value = sector_img[i];
         item.failed = fail_last && i == last;
         byte_stream.push_back(item);
         bytes_sent++;
      end
   endtask

   // A negative position sends the whole sector, otherwise the read fails there.
   task automatic push_sector(input int fail_at);
      if (fail_at < 0) push_span(0, 511, 1'b0);
      else push_span(0, fail_at, 1'b1);
   endtask

   task automatic wait_idle();
      while (bytes_accepted != bytes_sent || expected_mounts.size() != 0) @(posedge clock);
      // The last bytes of an unfinished sector may still be in the pipeline.
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (index == CSR_DEVICE_NUMBER) cfg_device = value;
      else cfg_partition = value;
   endtask

   task automatic set_config(input logic [2:0] device, input logic [2:0] partition);
      wait_idle();
      write_reg(CSR_DEVICE_NUMBER, device);
      write_reg(CSR_PARTITION_INDEX, partition);
   endtask

   // A short sector whose read fails within its first sixteen bytes.
   task automatic random_attempt();
      fill_noise();
      push_sector(int'($urandom_range(SHORT_SECTOR_LAST)));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      int roll;
      while (reset) @(posedge clock);
      set_config(3'd0, 3'd0);

      // Clean mount from the last slot whose sums wrap around 32 bits. The partition
      // index moves from slot zero to slot three in the middle of the MBR, so the
      // first entry's bytes up to offset 12 go by slot zero and the last entry's by slot three.
      build_mbr(3, 32'hFFFF_FFFF, 32'h0);
      push_span(0, int'(MBR_TABLE_BASE) + 12, 1'b0);
      set_config(3'd0, 3'd3);
      push_span(int'(MBR_TABLE_BASE) + 13, 511, 1'b0);
      build_boot(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0001);
      push_sector(-1);

      // MBR read failure on its first byte.
      fill_noise();
      push_sector(0);

      // Unsupported device; a burst of one-byte sectors while the receiver holds off.
      set_config(3'd7, 3'd0);
      holds_requested++;
      repeat (20) begin
         fill_noise();
         push_sector(0);
      end
      set_config(3'd1, 3'd4);
      push_sector(0);
      set_config(3'd0, 3'd4);
      push_sector(0);
      set_config(3'd0, 3'd7);
      push_sector(0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         roll = $urandom_range(99);
         if (roll < 75) set_config(3'd0, 3'($urandom_range(3)));
         else if (roll < 87) set_config(3'($urandom_range(7, 1)), 3'($urandom_range(7)));
         else set_config(3'd0, 3'($urandom_range(7, 4)));
         repeat (ATTEMPTS_PER_PHASE) random_attempt();
      end

      wait_idle();
      if (expected_mounts.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived", $time, expected_mounts.size());
      end
      if (mismatch_count == 0 && expected_mounts.size() == 0) begin
         $display("fat32_volume_header_parser regression: pass");
      end else begin
         $display("fat32_volume_header_parser regression: fail");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("fat32_volume_header_parser regression: fail");
      $finish;
   end

endmodule
